### sv/serial_register_slave_macros.svh
// Assertion macros shared by the serial register slave RTL.
`ifndef SERIAL_REGISTER_SLAVE_MACROS_SVH
`define SERIAL_REGISTER_SLAVE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SRS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srs: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srs: next-cycle check failed");

`endif

### sv/srs_pkg.sv
// Types and constants for the serial register slave.
`default_nettype none

package srs_pkg;

  localparam int LEN_W = 7;

  localparam logic [7:0] TYPE_PING      = 8'd0;
  localparam logic [7:0] TYPE_READ8     = 8'd1;
  localparam logic [7:0] TYPE_READ16    = 8'd2;
  localparam logic [7:0] TYPE_READ32    = 8'd3;
  localparam logic [7:0] TYPE_RUN_READ  = 8'd4;
  localparam logic [7:0] TYPE_WRITE8    = 8'd5;
  localparam logic [7:0] TYPE_WRITE16   = 8'd6;
  localparam logic [7:0] TYPE_WRITE32   = 8'd7;
  localparam logic [7:0] TYPE_RUN_WRITE = 8'd8;

  localparam logic [7:0] RESP_BIT = 8'h80;

  typedef struct packed {
    logic [7:0]  req_type;
    logic [7:0]  src_node;
    logic [15:0] reg_addr;
    logic [7:0]  run_count;
    logic [7:0]  byte_index;
    logic [7:0]  write_byte;
  } req_t;

  typedef struct packed {
    logic [7:0]       reply_dest;
    logic [7:0]       reply_from;
    logic [7:0]       reply_code;
    logic [LEN_W-1:0] reply_len;
    logic [7:0]       read_byte;
    logic             last_result;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDATA,
    ST_ACK
  } state_t;

endpackage

`default_nettype wire

### sv/srs_regmem.sv
// Byte-wide register memory: one write port, one registered read port.
`default_nettype none

module srs_regmem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output      logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/serial_register_slave.sv
// Serial register slave top level: request decode, read burst control, reply register.
//
// After reset the block sweeps the register memory to zero, one entry per cycle,
// so req_ready stays low until the sweep is done; node_id writes are taken during
// that time. A ping or a write byte that completes a write goes through the ACK
// state, which loads the reply register; a write byte that is not the last gets
// no reply. A read of n bytes gives n replies, one byte per cycle from the single read
// port of the memory while the reply register is free to take it. One request is
// worked on at a time; the next is taken once the last reply of the previous one
// sits in the reply register. Requests that are out of range, have a zero or
// oversized count, or carry an unknown type are dropped with no reply.
`default_nettype none
`include "serial_register_slave_macros.svh"

module serial_register_slave import srs_pkg::*; #(
  parameter int REG_COUNT   = 256,
  parameter int MAX_PAYLOAD = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  input  wire logic       req_valid,
  output      logic       req_ready,
  input  wire req_t       req,
  output      logic       rsp_valid,
  input  wire logic       rsp_ready,
  output      rsp_t       rsp
);

  localparam int AW = $clog2(REG_COUNT);
  localparam logic [16:0]      REG_LIMIT = 17'(REG_COUNT);
  localparam logic [AW-1:0]    CLR_LAST  = AW'(REG_COUNT - 1);
  localparam logic [7:0]       RUN_MAX   = 8'(MAX_PAYLOAD);

  state_t state, state_next;

  logic [7:0]       node_id;
  logic [AW-1:0]    clr_addr;
  logic [7:0]       hdr_dest;
  logic [7:0]       hdr_code;
  logic [LEN_W-1:0] rd_len;
  logic [LEN_W-1:0] rd_idx;
  logic [AW-1:0]    cur_addr;

  logic [LEN_W-1:0] req_len;
  logic             is_ping, is_read, is_write;
  logic [16:0]      last_addr;
  logic [16:0]      wr_addr_full;
  logic             in_range, idx_ok, wr_ok, ack_write;

  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [7:0]       mem_wdata, mem_rdata;

  logic             out_free, rsp_load, hdr_load, burst_step, clr_step, rd_last;
  rsp_t             rsp_next;

  srs_regmem #(
    .DEPTH (REG_COUNT),
    .AW    (AW)
  ) u_regmem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // request decode
  always_comb begin
    unique case (req.req_type)
      TYPE_READ8, TYPE_WRITE8:   req_len = LEN_W'(1);
      TYPE_READ16, TYPE_WRITE16: req_len = LEN_W'(2);
      TYPE_READ32, TYPE_WRITE32: req_len = LEN_W'(4);
      TYPE_RUN_READ, TYPE_RUN_WRITE: begin
        req_len = (req.run_count != 8'd0 && req.run_count <= RUN_MAX) ?
                  req.run_count[LEN_W-1:0] : '0;
      end
      default: req_len = '0;
    endcase
  end

  assign is_ping  = req.req_type == TYPE_PING;
  assign is_read  = req.req_type >= TYPE_READ8 && req.req_type <= TYPE_RUN_READ;
  assign is_write = req.req_type >= TYPE_WRITE8 && req.req_type <= TYPE_RUN_WRITE;

  assign last_addr    = {1'b0, req.reg_addr} + 17'(req_len) - 17'd1;
  assign in_range     = req_len != '0 && last_addr < REG_LIMIT;
  assign idx_ok       = req.byte_index < 8'(req_len);
  assign wr_ok        = is_write && in_range && idx_ok;
  assign ack_write    = wr_ok && req.byte_index == 8'(req_len) - 8'd1;
  assign wr_addr_full = {1'b0, req.reg_addr} + 17'(req.byte_index);

  assign out_free = !rsp_valid || rsp_ready;
  assign rd_last  = rd_idx == rd_len - LEN_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = clr_addr;
    mem_wdata  = 8'd0;
    mem_re     = 1'b0;
    mem_raddr  = req.reg_addr[AW-1:0];
    rsp_load   = 1'b0;
    hdr_load   = 1'b0;
    burst_step = 1'b0;
    clr_step   = 1'b0;
    rsp_next   = rsp;
    unique case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_addr == CLR_LAST) begin
          state_next = ST_IDLE;
        end else begin
          clr_step = 1'b1;
        end
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          hdr_load = 1'b1;
          priority if (is_ping) begin
            state_next = ST_ACK;
          end else if (is_read && in_range) begin
            mem_re     = 1'b1;
            state_next = ST_RDATA;
          end else if (wr_ok) begin
            mem_we    = 1'b1;
            mem_waddr = wr_addr_full[AW-1:0];
            mem_wdata = req.write_byte;
            if (ack_write) begin
              state_next = ST_ACK;
            end
          end else begin
            // dropped request
            state_next = ST_IDLE;
          end
        end
      end
      ST_RDATA: begin
        mem_raddr = cur_addr + AW'(1);
        if (out_free) begin
          rsp_load = 1'b1;
          rsp_next = '{reply_dest: hdr_dest, reply_from: node_id, reply_code: hdr_code,
                       reply_len: rd_len, read_byte: mem_rdata, last_result: rd_last};
          if (rd_last) begin
            state_next = ST_IDLE;
          end else begin
            mem_re     = 1'b1;
            burst_step = 1'b1;
          end
        end
      end
      ST_ACK: begin
        if (out_free) begin
          rsp_load   = 1'b1;
          rsp_next   = '{reply_dest: hdr_dest, reply_from: node_id, reply_code: hdr_code,
                         reply_len: '0, read_byte: 8'd0, last_result: 1'b1};
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_id   <= 8'd0;
      clr_addr  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        node_id <= cfg_wr_data;
      end
      if (clr_step) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_next;
    end
    if (hdr_load) begin
      hdr_dest <= req.src_node;
      hdr_code <= RESP_BIT | req.req_type;
      rd_len   <= req_len;
      rd_idx   <= '0;
      cur_addr <= req.reg_addr[AW-1:0];
    end else if (burst_step) begin
      rd_idx   <= rd_idx + LEN_W'(1);
      cur_addr <= cur_addr + AW'(1);
    end
  end

  `SRS_ASSERT_NOW(a_no_reply_while_clearing, clk, rst, state == ST_CLEAR, !rsp_valid)
  `SRS_ASSERT_NOW(a_burst_index_in_len, clk, rst, state == ST_RDATA, rd_idx < rd_len)
  `SRS_ASSERT_NOW(a_write_only_clear_or_idle, clk, rst, mem_we,
                  state == ST_CLEAR || state == ST_IDLE)
  `SRS_ASSERT_NEXT(a_last_returns_idle, clk, rst, rsp_load && rsp_next.last_result,
                   state == ST_IDLE)
  `SRS_ASSERT_NOW(a_reply_code_marked, clk, rst, rsp_valid, rsp.reply_code[7])

endmodule

`default_nettype wire
